>>> rtl/owb_pkg.sv
package owb_pkg;

  localparam int DUR_W     = 10;
  localparam int NUM_CFG   = 8;
  localparam int REG_IDX_W = 3;
  localparam int CFG_IDX_W = 4;
  localparam int BYTE_W    = 8;
  localparam int BC_W      = 3;

  typedef logic [DUR_W-1:0] dur_t;

  typedef struct packed {
    dur_t [NUM_CFG-1:0] dur;
  } cfg_t;

  // register indexes of the timing registers
  typedef enum logic [REG_IDX_W-1:0] {
    REG_RESET_PHASE   = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_W1_LOW        = 3'd2,
    REG_W1_TAIL       = 3'd3,
    REG_W0_LOW        = 3'd4,
    REG_RD_LOW        = 3'd5,
    REG_RD_SAMPLE     = 3'd6,
    REG_RD_TAIL       = 3'd7
  } reg_idx_t;

  localparam logic [NUM_CFG-1:0][DUR_W-1:0] CFG_RESET = {
    10'd50, 10'd5, 10'd5, 10'd70, 10'd55, 10'd10, 10'd70, 10'd500
  };

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_REC  = 4'd3,
    PH_WR_LOW   = 4'd4,
    PH_WR_TAIL  = 4'd5,
    PH_RD_LOW   = 4'd6,
    PH_RD_WAIT  = 4'd7,
    PH_RD_TAIL  = 4'd8
  } phase_t;

  typedef struct packed {
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic              presence;
    logic [BYTE_W-1:0] rx_byte;
  } res_t;

endpackage

>>> rtl/owb_in_if.sv
interface owb_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 cmd;
  logic [owb_pkg::BYTE_W-1:0] tx_byte;
  logic                       bus_level;

  modport source (output valid, output cmd, output tx_byte, output bus_level, input ready);
  modport sink (input valid, input cmd, input tx_byte, input bus_level, output ready);
endinterface

>>> rtl/owb_out_if.sv
interface owb_out_if;
  logic                       valid;
  logic                       ready;
  logic                       drive_low;
  logic                       busy_res;
  logic                       done_res;
  logic                       presence;
  logic [owb_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output presence, output rx_byte, input ready);
  modport sink (input valid, input drive_low, input busy_res, input done_res,
                input presence, input rx_byte, output ready);
endinterface

>>> rtl/owb_cfg_if.sv
interface owb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [owb_pkg::CFG_IDX_W-1:0] reg_index;
  logic [owb_pkg::DUR_W-1:0]     wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

>>> rtl/owb_cfg_regs.sv
module owb_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  owb_cfg_if.sink       cfg_ch,
  output owb_pkg::cfg_t cfg
);

  logic [owb_pkg::NUM_CFG-1:0][owb_pkg::DUR_W-1:0] dur_r;
  logic                                            wr_en;

  assign cfg_ch.ready = 1'b1;
  // indexes past the register list are dropped
  assign wr_en = cfg_ch.valid &&
                 (cfg_ch.reg_index < owb_pkg::CFG_IDX_W'(owb_pkg::NUM_CFG));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r <= owb_pkg::CFG_RESET;
    end else if (wr_en) begin
      dur_r[cfg_ch.reg_index[owb_pkg::REG_IDX_W-1:0]] <= cfg_ch.wdata;
    end
  end

  assign cfg.dur = dur_r;

endmodule

>>> rtl/owb_core.sv
module owb_core #(
  parameter int BITS_PER_BYTE = 8,
  parameter int TIMER_BITS    = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  owb_pkg::cmd_t              cmd,
  input  logic [owb_pkg::BYTE_W-1:0] tx_byte,
  input  logic                       bus_level,
  input  owb_pkg::cfg_t              cfg,
  output owb_pkg::res_t              res_nxt
);

  localparam int LW = (TIMER_BITS > owb_pkg::DUR_W) ? TIMER_BITS : owb_pkg::DUR_W;
  localparam logic [TIMER_BITS-1:0]      TMAX     = {TIMER_BITS{1'b1}};
  localparam logic [LW-1:0]              TMAX_EXT = LW'(TMAX);
  localparam logic [owb_pkg::BC_W-1:0]   LAST_BIT = owb_pkg::BC_W'(BITS_PER_BYTE - 1);
  localparam logic [owb_pkg::BC_W:0]     BITS_CNT = (owb_pkg::BC_W + 1)'(BITS_PER_BYTE);

  typedef struct packed {
    owb_pkg::phase_t            ph;
    logic [owb_pkg::BC_W-1:0]   bc;
    logic [owb_pkg::BYTE_W-1:0] sh;
    logic                       pr;
    logic [owb_pkg::BYTE_W-1:0] rx;
    logic                       dn;
  } st_t;

  owb_pkg::phase_t            phase_r;
  logic [TIMER_BITS-1:0]      timer_r;
  logic [owb_pkg::BC_W-1:0]   bit_r;
  logic [owb_pkg::BYTE_W-1:0] shift_r;
  logic                       pres_r;
  logic [owb_pkg::BYTE_W-1:0] rx_r;

  st_t                                       st_nxt;
  logic [TIMER_BITS-1:0]                     timer_nxt;
  logic [owb_pkg::NUM_CFG-1:0]               zf;
  logic [owb_pkg::NUM_CFG-1:0][TIMER_BITS-1:0] len;
  logic [TIMER_BITS-1:0]                     cur_len;

  // does the phase that s sits in last zero ticks
  function automatic logic zero_len(st_t s, logic [owb_pkg::NUM_CFG-1:0] z);
    logic r;
    r = 1'b0;
    unique case (s.ph)
      owb_pkg::PH_IDLE:     r = 1'b0;
      owb_pkg::PH_RST_LOW:  r = z[owb_pkg::REG_RESET_PHASE];
      owb_pkg::PH_RST_WAIT: r = z[owb_pkg::REG_PRESENCE_WAIT];
      owb_pkg::PH_RST_REC:  r = z[owb_pkg::REG_RESET_PHASE];
      owb_pkg::PH_WR_LOW:   r = s.sh[0] ? z[owb_pkg::REG_W1_LOW] : z[owb_pkg::REG_W0_LOW];
      owb_pkg::PH_WR_TAIL:  r = s.sh[0] ? z[owb_pkg::REG_W1_TAIL] : 1'b1;
      owb_pkg::PH_RD_LOW:   r = z[owb_pkg::REG_RD_LOW];
      owb_pkg::PH_RD_WAIT:  r = z[owb_pkg::REG_RD_SAMPLE];
      owb_pkg::PH_RD_TAIL:  r = z[owb_pkg::REG_RD_TAIL];
      default:              r = 1'b0;
    endcase
    return r;
  endfunction

  // phase transition at the end of a phase, with its sample or completion
  function automatic st_t end_phase(st_t s, logic level);
    st_t r;
    r = s;
    unique case (s.ph)
      owb_pkg::PH_RST_LOW:  r.ph = owb_pkg::PH_RST_WAIT;
      owb_pkg::PH_RST_WAIT: begin
        r.pr = !level;
        r.ph = owb_pkg::PH_RST_REC;
      end
      owb_pkg::PH_RST_REC: begin
        r.ph = owb_pkg::PH_IDLE;
        r.dn = 1'b1;
      end
      owb_pkg::PH_WR_LOW:   r.ph = owb_pkg::PH_WR_TAIL;
      owb_pkg::PH_WR_TAIL: begin
        r.sh = s.sh >> 1;
        if (s.bc >= LAST_BIT) begin
          r.ph = owb_pkg::PH_IDLE;
          r.dn = 1'b1;
        end else begin
          r.bc = s.bc + 1'b1;
          r.ph = owb_pkg::PH_WR_LOW;
        end
      end
      owb_pkg::PH_RD_LOW:   r.ph = owb_pkg::PH_RD_WAIT;
      owb_pkg::PH_RD_WAIT: begin
        if (level) begin
          r.sh = s.sh | (owb_pkg::BYTE_W'(1) << s.bc);
        end
        r.ph = owb_pkg::PH_RD_TAIL;
      end
      owb_pkg::PH_RD_TAIL: begin
        if (s.bc >= LAST_BIT) begin
          r.rx = s.sh;
          r.ph = owb_pkg::PH_IDLE;
          r.dn = 1'b1;
        end else begin
          r.bc = s.bc + 1'b1;
          r.ph = owb_pkg::PH_RD_LOW;
        end
      end
      owb_pkg::PH_IDLE:     r.ph = owb_pkg::PH_IDLE;
      default:              r.ph = owb_pkg::PH_IDLE;
    endcase
    return r;
  endfunction

  function automatic st_t step(st_t s, logic [owb_pkg::NUM_CFG-1:0] z, logic level);
    st_t r;
    r = s;
    if (s.ph != owb_pkg::PH_IDLE && zero_len(s, z)) begin
      r = end_phase(s, level);
    end
    return r;
  endfunction

  // write: finish a zero tail, then skip every slot whose low and tail are both empty
  function automatic st_t wr_settle(st_t s, logic [owb_pkg::NUM_CFG-1:0] z);
    st_t                      r;
    logic                     p1;
    logic                     p0;
    logic                     found;
    logic [owb_pkg::BC_W-1:0] k;
    logic [owb_pkg::BC_W:0]   pos;
    r     = s;
    p1    = z[owb_pkg::REG_W1_LOW] & z[owb_pkg::REG_W1_TAIL];
    p0    = z[owb_pkg::REG_W0_LOW];
    found = 1'b0;
    k     = '0;
    pos   = '0;
    if (r.ph == owb_pkg::PH_WR_TAIL && (!r.sh[0] || z[owb_pkg::REG_W1_TAIL])) begin
      r = end_phase(r, 1'b0);
    end
    if (r.ph == owb_pkg::PH_WR_LOW) begin
      for (int i = 0; i < owb_pkg::BYTE_W; i++) begin
        pos = {1'b0, r.bc} + (owb_pkg::BC_W + 1)'(i);
        if (!found && pos < BITS_CNT && !(r.sh[i] ? p1 : p0)) begin
          found = 1'b1;
          k     = owb_pkg::BC_W'(i);
        end
      end
      if (found) begin
        r.bc = r.bc + k;
        r.sh = r.sh >> k;
        r.ph = (r.sh[0] && z[owb_pkg::REG_W1_LOW]) ? owb_pkg::PH_WR_TAIL : owb_pkg::PH_WR_LOW;
      end else begin
        r.bc = LAST_BIT;
        r.ph = owb_pkg::PH_IDLE;
        r.dn = 1'b1;
      end
    end
    return r;
  endfunction

  // run through every zero-length phase reachable on this word
  function automatic st_t settle(st_t s, logic [owb_pkg::NUM_CFG-1:0] z, logic level);
    st_t                    r;
    logic [owb_pkg::BC_W:0] first;
    r     = s;
    first = '0;
    if (s.ph == owb_pkg::PH_RST_LOW || s.ph == owb_pkg::PH_RST_WAIT ||
        s.ph == owb_pkg::PH_RST_REC) begin
      r = step(step(step(s, z, level), z, level), z, level);
    end else if (s.ph == owb_pkg::PH_WR_LOW || s.ph == owb_pkg::PH_WR_TAIL) begin
      r = wr_settle(s, z);
    end else if (s.ph == owb_pkg::PH_RD_LOW || s.ph == owb_pkg::PH_RD_WAIT ||
                 s.ph == owb_pkg::PH_RD_TAIL) begin
      if (z[owb_pkg::REG_RD_LOW] && z[owb_pkg::REG_RD_SAMPLE] && z[owb_pkg::REG_RD_TAIL]) begin
        // empty read slots: every remaining bit takes the current line level
        first = {1'b0, s.bc} + ((s.ph == owb_pkg::PH_RD_TAIL) ? 1'b1 : 1'b0);
        for (int i = 0; i < owb_pkg::BYTE_W; i++) begin
          if ((owb_pkg::BC_W + 1)'(i) >= first && (owb_pkg::BC_W + 1)'(i) < BITS_CNT) begin
            r.sh[i] = s.sh[i] | level;
          end
        end
        r.rx = r.sh;
        r.bc = LAST_BIT;
        r.ph = owb_pkg::PH_IDLE;
        r.dn = 1'b1;
      end else begin
        // at most two zero phases in a row once one of the three is non-empty
        r = step(step(step(s, z, level), z, level), z, level);
      end
    end
    return r;
  endfunction

  always_comb begin
    logic [LW-1:0] ext;
    ext = '0;
    for (int i = 0; i < owb_pkg::NUM_CFG; i++) begin
      zf[i]  = (cfg.dur[i] == '0);
      ext    = LW'(cfg.dur[i]);
      len[i] = (ext > TMAX_EXT) ? TMAX : TIMER_BITS'(ext);
    end
  end

  always_comb begin
    unique case (phase_r)
      owb_pkg::PH_IDLE:     cur_len = '0;
      owb_pkg::PH_RST_LOW:  cur_len = len[owb_pkg::REG_RESET_PHASE];
      owb_pkg::PH_RST_WAIT: cur_len = len[owb_pkg::REG_PRESENCE_WAIT];
      owb_pkg::PH_RST_REC:  cur_len = len[owb_pkg::REG_RESET_PHASE];
      owb_pkg::PH_WR_LOW:   cur_len = shift_r[0] ? len[owb_pkg::REG_W1_LOW]
                                                 : len[owb_pkg::REG_W0_LOW];
      owb_pkg::PH_WR_TAIL:  cur_len = shift_r[0] ? len[owb_pkg::REG_W1_TAIL] : '0;
      owb_pkg::PH_RD_LOW:   cur_len = len[owb_pkg::REG_RD_LOW];
      owb_pkg::PH_RD_WAIT:  cur_len = len[owb_pkg::REG_RD_SAMPLE];
      owb_pkg::PH_RD_TAIL:  cur_len = len[owb_pkg::REG_RD_TAIL];
      default:              cur_len = '0;
    endcase
  end

  always_comb begin
    st_t                   cur;
    logic [TIMER_BITS-1:0] tm_inc;
    logic                  run;
    cur.ph    = phase_r;
    cur.bc    = bit_r;
    cur.sh    = shift_r;
    cur.pr    = pres_r;
    cur.rx    = rx_r;
    cur.dn    = 1'b0;
    st_nxt    = cur;
    timer_nxt = timer_r;
    run       = 1'b0;
    tm_inc    = (timer_r == TMAX) ? timer_r : timer_r + 1'b1;
    if (go) begin
      if (cmd == owb_pkg::CMD_TICK) begin
        if (phase_r != owb_pkg::PH_IDLE) begin
          timer_nxt = tm_inc;
          if (tm_inc >= cur_len) begin
            st_nxt    = end_phase(cur, bus_level);
            timer_nxt = '0;
            run       = 1'b1;
          end
        end
      end else if (phase_r == owb_pkg::PH_IDLE) begin
        timer_nxt = '0;
        st_nxt.bc = '0;
        run       = 1'b1;
        unique case (cmd)
          owb_pkg::CMD_RESET: begin
            st_nxt.sh = '0;
            st_nxt.ph = owb_pkg::PH_RST_LOW;
          end
          owb_pkg::CMD_WRITE: begin
            st_nxt.sh = tx_byte;
            st_nxt.ph = owb_pkg::PH_WR_LOW;
          end
          default: begin
            st_nxt.sh = '0;
            st_nxt.ph = owb_pkg::PH_RD_LOW;
          end
        endcase
      end
    end
    if (run) begin
      st_nxt = settle(st_nxt, zf, bus_level);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= owb_pkg::PH_IDLE;
      timer_r <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      pres_r  <= 1'b0;
      rx_r    <= '0;
    end else if (go) begin
      phase_r <= st_nxt.ph;
      timer_r <= timer_nxt;
      bit_r   <= st_nxt.bc;
      shift_r <= st_nxt.sh;
      pres_r  <= st_nxt.pr;
      rx_r    <= st_nxt.rx;
    end
  end

  assign res_nxt.drive_low = (st_nxt.ph == owb_pkg::PH_RST_LOW) ||
                             (st_nxt.ph == owb_pkg::PH_WR_LOW) ||
                             (st_nxt.ph == owb_pkg::PH_RD_LOW);
  assign res_nxt.busy_res  = (st_nxt.ph != owb_pkg::PH_IDLE);
  assign res_nxt.done_res  = st_nxt.dn;
  assign res_nxt.presence  = st_nxt.pr;
  assign res_nxt.rx_byte   = st_nxt.rx;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    go && res_nxt.done_res |-> !res_nxt.busy_res)
    else $error("completion reported while still busy");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !go |=> $stable(phase_r) && $stable(timer_r) && $stable(rx_r))
    else $error("state moved without a word");

  a_busy_cmd_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    go && cmd != owb_pkg::CMD_TICK && phase_r != owb_pkg::PH_IDLE
    |=> $stable(phase_r) && $stable(timer_r) && $stable(bit_r) && $stable(shift_r))
    else $error("command taken while busy");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != owb_pkg::PH_IDLE |-> bit_r <= LAST_BIT)
    else $error("slot counter past the last bit");

endmodule

>>> rtl/onewire_bus_master.sv
// channel  dir  handshake     payload
// in_ch    in   valid/ready   cmd[1:0], tx_byte[7:0], bus_level
// out_ch   out  valid/ready   drive_low, busy_res, done_res, presence, rx_byte[7:0]
// cfg_ch   in   valid/ready   reg_index[3:0], wdata[9:0] (ready always high)
//
// one word accepted per cycle while the result register can move on, one result word per input word;
// each word passes input register -> state update -> result register in one pass
// rst_n synchronous active low: bus idle, timing registers back to defaults
// out_ch.ready low holds the result; one more word waits in the input register,
// then in_ch.ready drops until the result is taken
module onewire_bus_master #(
  parameter int BITS_PER_BYTE = 8,
  parameter int TIMER_BITS    = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  owb_in_if.sink     in_ch,
  owb_out_if.source  out_ch,
  owb_cfg_if.sink    cfg_ch
);

  // input register
  logic                       in_v_r;
  logic                       in_v_nxt;
  owb_pkg::cmd_t              in_cmd_r;
  logic [owb_pkg::BYTE_W-1:0] in_tx_r;
  logic                       in_lvl_r;

  // result register
  logic                       out_v_r;
  logic                       out_v_nxt;
  owb_pkg::res_t              out_res_r;
  owb_pkg::res_t              out_res_nxt;

  owb_pkg::cfg_t              cfg;
  logic                       in_take;
  logic                       advance;

  // held word moves on when the result slot is free or being emptied
  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign in_v_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : in_v_r);
  assign out_v_nxt = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_cmd_r <= owb_pkg::cmd_t'(in_ch.cmd);
      in_tx_r  <= in_ch.tx_byte;
      in_lvl_r <= in_ch.bus_level;
    end
    if (advance) begin
      out_res_r <= out_res_nxt;
    end
  end

  owb_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // bus sequencer: phase, slot timer, bit counter and shift register
  owb_core #(
    .BITS_PER_BYTE (BITS_PER_BYTE),
    .TIMER_BITS    (TIMER_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (advance),
    .cmd       (in_cmd_r),
    .tx_byte   (in_tx_r),
    .bus_level (in_lvl_r),
    .cfg       (cfg),
    .res_nxt   (out_res_nxt)
  );

  assign out_ch.valid     = out_v_r;
  assign out_ch.drive_low = out_res_r.drive_low;
  assign out_ch.busy_res  = out_res_r.busy_res;
  assign out_ch.done_res  = out_res_r.done_res;
  assign out_ch.presence  = out_res_r.presence;
  assign out_ch.rx_byte   = out_res_r.rx_byte;

endmodule
